FILE: rtl/bbe_pkg.sv
// Shared types and constants for the Bernstein basis evaluator.
package bbe_pkg;

  // Width of the degree register and of the basis index field
  localparam int unsigned DEGREE_W = 4;
  localparam int unsigned INDEX_W  = 4;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } bbe_state_e;

  // Controls broadcast to every triangle cell
  typedef struct packed {
    logic init;  // load the first row of the triangle
    logic step;  // advance one row
    logic snap;  // keep the current row as the row below the top
  } bbe_cell_ctrl_t;

  // Controls broadcast to every output cell
  typedef struct packed {
    logic load;   // take a finished triangle
    logic shift;  // move every result one place toward the port
  } bbe_out_ctrl_t;

endpackage

FILE: rtl/bernstein_basis_eval.sv
// Bernstein basis evaluator top level: sequencer, triangle cells and output cells.
//
// Usage: write the degree p (1 to 8; 0 acts as 1, larger values as MAX_DEGREE)
// through degree_we_i/degree_i while the block is idle; reset sets it to 1.
// Each xi transfer on the input channel (valid/stall, xi above one is taken
// as one) yields p+1 result transfers, index 0 to p, with last_o on index p.
// A row of MAX_DEGREE+1 triangle cells builds one de Casteljau row per
// cycle, each cell taking its left neighbor's entry, so a triangle of
// degree p is built row by row after the transfer and then moves into the
// output cells. The output cells emit one result per cycle while the
// receiver does not stall; the next item is taken on the same edge that a
// finished triangle moves into the output cells, so a new triangle is
// built while the previous results drain.
// When the receiver stalls, the current result holds on the ports and the
// finished triangle waits in the cells; in_stall_o stays high while a
// triangle is built and while it waits for the output cells.
// Reset empties both stages; no clearing pass is needed.
module bernstein_basis_eval #(
  parameter int unsigned MAX_DEGREE = 8,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          degree_we_i,
  input  logic [bbe_pkg::DEGREE_W-1:0]  degree_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [FRAC_BITS:0]            xi_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bbe_pkg::INDEX_W-1:0]   basis_index_o,
  output logic [FRAC_BITS:0]            basis_value_o,
  output logic [FRAC_BITS+4:0]          basis_slope_o,
  output logic                          last_o
);
  import bbe_pkg::*;

  localparam int unsigned N  = MAX_DEGREE + 1;
  localparam int unsigned VW = FRAC_BITS + 1;
  localparam int unsigned SW = FRAC_BITS + 5;
  localparam int unsigned KW = $clog2(MAX_DEGREE + 1);
  localparam logic [VW-1:0] ONE_FX = VW'(1) << FRAC_BITS;

  logic [DEGREE_W-1:0] degree_q;
  bbe_state_e          state_q, state_d;
  logic [KW-1:0]       p_q, p_eff;
  logic [KW-1:0]       k_q;
  logic [VW-1:0]       x_q, xc_q, x_sat;
  logic                in_xfer, out_xfer, buf_load;
  logic                buf_valid_q;
  logic [KW-1:0]       buf_p_q, idx_q;
  logic                buf_last;
  bbe_cell_ctrl_t      cell_ctrl;
  bbe_out_ctrl_t       out_ctrl;

  logic [VW-1:0] row_w   [N];
  logic [VW-1:0] prev_w  [N];
  logic [VW-1:0] value_w [N];
  logic [SW-1:0] slope_w [N];

  // Degree register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= DEGREE_W'(1);
    end else if (degree_we_i) begin
      degree_q <= degree_i;
    end
  end

  // Saturate degree and parameter
  always_comb begin
    if (degree_q == '0) begin
      p_eff = KW'(1);
    end else if (int'(degree_q) > int'(MAX_DEGREE)) begin
      p_eff = KW'(MAX_DEGREE);
    end else begin
      p_eff = KW'(degree_q);
    end
    x_sat = (xi_i > ONE_FX) ? ONE_FX : xi_i;
  end

  // Handshakes
  assign buf_last = (idx_q == buf_p_q);
  assign out_xfer = buf_valid_q && !out_stall_i;
  assign buf_load = (state_q == ST_HOLD) && (!buf_valid_q || (out_xfer && buf_last));
  assign in_stall_o = !((state_q == ST_IDLE) || buf_load);
  assign in_xfer = in_valid_i && !in_stall_o;

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (k_q == p_q) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (buf_load) state_d = in_xfer ? ST_RUN : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      p_q     <= KW'(1);
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        k_q <= KW'(1);
        p_q <= p_eff;
      end else if (state_q == ST_RUN) begin
        k_q <= k_q + KW'(1);
      end
    end
  end

  // Capture the parameter and its complement
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      x_q  <= x_sat;
      xc_q <= ONE_FX - x_sat;
    end
  end

  // Cell controls
  always_comb begin
    cell_ctrl.init = in_xfer;
    cell_ctrl.step = (state_q == ST_RUN);
    cell_ctrl.snap = (state_q == ST_RUN) && (k_q == p_q);
    out_ctrl.load  = buf_load;
    out_ctrl.shift = out_xfer;
  end

  // Row of triangle cells and row of output cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [VW-1:0] left_w, prev_lo_w, next_value_w;
    logic [SW-1:0] next_slope_w;

    if (i == 0) begin : g_first
      assign left_w    = '0;
      assign prev_lo_w = '0;
    end else begin : g_rest
      assign left_w    = row_w[i-1];
      assign prev_lo_w = prev_w[i-1];
    end

    if (i == N - 1) begin : g_end
      assign next_value_w = '0;
      assign next_slope_w = '0;
    end else begin : g_mid
      assign next_value_w = value_w[i+1];
      assign next_slope_w = slope_w[i+1];
    end

    bbe_cell #(
      .FRAC_BITS (FRAC_BITS),
      .INIT_ONE  (i == 0)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl),
      .x_i    (x_q),
      .xc_i   (xc_q),
      .left_i (left_w),
      .row_o  (row_w[i]),
      .prev_o (prev_w[i])
    );

    bbe_out_cell #(
      .FRAC_BITS (FRAC_BITS),
      .KW        (KW)
    ) u_out (
      .clk_i        (clk_i),
      .ctrl_i       (out_ctrl),
      .degree_i     (p_q),
      .row_i        (row_w[i]),
      .prev_lo_i    (prev_lo_w),
      .prev_hi_i    (prev_w[i]),
      .next_value_i (next_value_w),
      .next_slope_i (next_slope_w),
      .value_o      (value_w[i]),
      .slope_o      (slope_w[i])
    );
  end

  // Output sequencing: count results, drop valid after the last transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
      buf_p_q     <= KW'(1);
      idx_q       <= '0;
    end else if (buf_load) begin
      buf_valid_q <= 1'b1;
      buf_p_q     <= p_q;
      idx_q       <= '0;
    end else if (out_xfer) begin
      if (buf_last) begin
        buf_valid_q <= 1'b0;
      end
      idx_q <= idx_q + KW'(1);
    end
  end

  assign out_valid_o   = buf_valid_q;
  assign basis_index_o = INDEX_W'(idx_q);
  assign basis_value_o = value_w[0];
  assign basis_slope_o = slope_w[0];
  assign last_o        = buf_last;

endmodule

FILE: rtl/bbe_cell.sv
// One triangle cell: holds entry i of the current row and of the snapped row.
module bbe_cell #(
  parameter int unsigned FRAC_BITS = 16,
  parameter bit          INIT_ONE  = 1'b0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bbe_pkg::bbe_cell_ctrl_t ctrl_i,
  input  logic [FRAC_BITS:0]     x_i,
  input  logic [FRAC_BITS:0]     xc_i,
  input  logic [FRAC_BITS:0]     left_i,
  output logic [FRAC_BITS:0]     row_o,
  output logic [FRAC_BITS:0]     prev_o
);
  import bbe_pkg::*;

  localparam int unsigned VW = FRAC_BITS + 1;
  localparam int unsigned PW = 2 * VW;
  localparam logic [VW-1:0] ONE_FX  = VW'(1) << FRAC_BITS;
  localparam logic [PW-1:0] HALF_FX = PW'(1) << (FRAC_BITS - 1);

  logic [VW-1:0] row_q, row_d;
  logic [VW-1:0] prev_q;
  logic [PW-1:0] prod_a, prod_b;
  logic [VW:0]   term_a, term_b, sum;

  // Two rounded products and their sum, clamped to one
  always_comb begin
    prod_a = (PW'(xc_i) * PW'(row_q)) + HALF_FX;
    prod_b = (PW'(x_i) * PW'(left_i)) + HALF_FX;
    term_a = (VW+1)'(prod_a >> FRAC_BITS);
    term_b = (VW+1)'(prod_b >> FRAC_BITS);
    sum    = term_a + term_b;
    row_d  = (sum > {1'b0, ONE_FX}) ? ONE_FX : sum[VW-1:0];
  end

  // Hold the row entry; start a new triangle or advance one row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (ctrl_i.init) begin
      row_q <= INIT_ONE ? ONE_FX : '0;
    end else if (ctrl_i.step) begin
      row_q <= row_d;
    end
  end

  // Keep the row before the last step for the slope
  always_ff @(posedge clk_i) begin
    if (ctrl_i.snap) begin
      prev_q <= row_q;
    end
  end

  assign row_o  = row_q;
  assign prev_o = prev_q;

endmodule

FILE: rtl/bbe_out_cell.sv
// One output cell: holds a finished basis value and slope, shifts toward the port.
module bbe_out_cell #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned KW        = 4
) (
  input  logic                   clk_i,
  input  bbe_pkg::bbe_out_ctrl_t ctrl_i,
  input  logic [KW-1:0]          degree_i,
  input  logic [FRAC_BITS:0]     row_i,
  input  logic [FRAC_BITS:0]     prev_lo_i,
  input  logic [FRAC_BITS:0]     prev_hi_i,
  input  logic [FRAC_BITS:0]     next_value_i,
  input  logic [FRAC_BITS+4:0]   next_slope_i,
  output logic [FRAC_BITS:0]     value_o,
  output logic [FRAC_BITS+4:0]   slope_o
);
  import bbe_pkg::*;

  localparam int unsigned VW = FRAC_BITS + 1;
  localparam int unsigned DW = FRAC_BITS + 2;
  localparam int unsigned MW = DW + KW + 1;
  localparam int unsigned SW = FRAC_BITS + 5;

  logic [VW-1:0]        value_q;
  logic [SW-1:0]        slope_q;
  logic signed [DW-1:0] diff;
  logic signed [MW-1:0] prod;

  // Slope is degree times the difference of the neighboring snapped entries
  always_comb begin
    diff = $signed({1'b0, prev_lo_i}) - $signed({1'b0, prev_hi_i});
    prod = MW'(diff) * $signed(MW'(degree_i));
  end

  // Load a finished triangle or shift toward the port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      value_q <= row_i;
      slope_q <= prod[SW-1:0];
    end else if (ctrl_i.shift) begin
      value_q <= next_value_i;
      slope_q <= next_slope_i;
    end
  end

  assign value_o = value_q;
  assign slope_o = slope_q;

endmodule
